### hw/rtl/cfs_pkg.sv
// ---------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the capture filter, scorer and sorter.
// ---------------------------------------------------------------------------
package cfs_pkg;

   // Field widths
   localparam int IDX_W    = 6;
   localparam int SCORE_W  = 23;
   localparam int PIECE_W  = 4;
   localparam int SQ_W     = 6;
   localparam int KIND_W   = 3;
   localparam int VAL_W    = 15;
   localparam int COUNT_W  = 7;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // Default list length
   localparam int CFS_MAX_MOVES = 64;

   // Score multipliers
   localparam int VICTIM_MUL = 100;
   localparam int PROMO_MUL  = 10;

   // Opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   // Move kinds
   localparam logic [KIND_W-1:0] MK_QUIET     = 3'd0;
   localparam logic [KIND_W-1:0] MK_CAPTURE   = 3'd1;
   localparam logic [KIND_W-1:0] MK_CAP_PROMO = 3'd2;
   localparam logic [KIND_W-1:0] MK_EN_PASS   = 3'd3;
   localparam logic [KIND_W-1:0] MK_PROMO     = 3'd4;

   // Piece codes
   localparam logic [PIECE_W-1:0] PC_EMPTY    = 4'd0;
   localparam logic [PIECE_W-1:0] PC_W_PAWN   = 4'd1;
   localparam logic [PIECE_W-1:0] PC_W_KNIGHT = 4'd2;
   localparam logic [PIECE_W-1:0] PC_W_BISHOP = 4'd3;
   localparam logic [PIECE_W-1:0] PC_W_ROOK   = 4'd4;
   localparam logic [PIECE_W-1:0] PC_W_QUEEN  = 4'd5;
   localparam logic [PIECE_W-1:0] PC_W_KING   = 4'd6;
   localparam logic [PIECE_W-1:0] PC_B_PAWN   = 4'd7;
   localparam logic [PIECE_W-1:0] PC_B_KNIGHT = 4'd8;
   localparam logic [PIECE_W-1:0] PC_B_BISHOP = 4'd9;
   localparam logic [PIECE_W-1:0] PC_B_ROOK   = 4'd10;
   localparam logic [PIECE_W-1:0] PC_B_QUEEN  = 4'd11;
   localparam logic [PIECE_W-1:0] PC_B_KING   = 4'd12;

   // Register indexes; the piece values double as value table slots
   localparam logic [2:0] CSR_PAWN   = 3'd0;
   localparam logic [2:0] CSR_KNIGHT = 3'd1;
   localparam logic [2:0] CSR_BISHOP = 3'd2;
   localparam logic [2:0] CSR_ROOK   = 3'd3;
   localparam logic [2:0] CSR_QUEEN  = 3'd4;
   localparam logic [2:0] CSR_KING   = 3'd5;
   localparam logic [2:0] CSR_WTM    = 3'd6;

   // Register reset values
   localparam logic [VAL_W-1:0] RST_PAWN   = 15'd100;
   localparam logic [VAL_W-1:0] RST_KNIGHT = 15'd300;
   localparam logic [VAL_W-1:0] RST_BISHOP = 15'd300;
   localparam logic [VAL_W-1:0] RST_ROOK   = 15'd500;
   localparam logic [VAL_W-1:0] RST_QUEEN  = 15'd900;
   localparam logic [VAL_W-1:0] RST_KING   = 15'd10000;

   // One slot of the sorting row
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [IDX_W-1:0]          index;
   } cfs_entry_type;

   // Row control
   typedef struct packed {
      logic insert;
      logic shift;
   } cfs_ctrl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_INSERT,
      ST_DRAIN
   } cfs_state_type;

endpackage

### hw/rtl/cfs_cell.sv
// ---------------------------------------------------------------------------
// cfs_cell
// One slot of the insertion row: holds, takes the new entry, or takes a
// neighbour's entry.
// ---------------------------------------------------------------------------
module cfs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cfs_pkg::cfs_ctrl_type  ctrl,
   input  cfs_pkg::cfs_entry_type new_entry,
   input  cfs_pkg::cfs_entry_type prev_entry,
   input  logic                  prev_keep,
   input  cfs_pkg::cfs_entry_type next_entry,
   output cfs_pkg::cfs_entry_type entry,
   output logic                  keep
);
   import cfs_pkg::*;

   cfs_entry_type entry_ff;
   cfs_entry_type entry_in;

   // Stays put on insert when its score is at least the new one (ties keep order)
   assign keep = entry_ff.valid && ($signed(entry_ff.score) >= $signed(new_entry.score));

   // Next slot contents
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   // Slot register; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/cfs_chain.sv
// ---------------------------------------------------------------------------
// cfs_chain
// Row of insertion cells kept in descending score order; the head is read
// out and the row shifts towards it during the drain.
// ---------------------------------------------------------------------------
module cfs_chain #(
   parameter int NUM_CELLS = cfs_pkg::CFS_MAX_MOVES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfs_pkg::cfs_ctrl_type  ctrl,
   input  cfs_pkg::cfs_entry_type new_entry,
   output cfs_pkg::cfs_entry_type head
);
   import cfs_pkg::*;

   cfs_entry_type entries [NUM_CELLS];
   cfs_entry_type prevs   [NUM_CELLS];
   cfs_entry_type nexts   [NUM_CELLS];
   logic          keeps   [NUM_CELLS];
   logic          pkeeps  [NUM_CELLS];

   // Neighbour wiring; the ends see an empty slot
   always_comb begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (i == 0) begin
            prevs[i]  = '0;
            pkeeps[i] = 1'b1;
         end else begin
            prevs[i]  = entries[i-1];
            pkeeps[i] = keeps[i-1];
         end
         if (i == NUM_CELLS - 1) begin
            nexts[i] = '0;
         end else begin
            nexts[i] = entries[i+1];
         end
      end
   end

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      cfs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_entry (prevs[g]),
         .prev_keep  (pkeeps[g]),
         .next_entry (nexts[g]),
         .entry      (entries[g]),
         .keep       (keeps[g])
      );
   end

   assign head = entries[0];

endmodule

### hw/rtl/capture_filter_score_sort.sv
// ---------------------------------------------------------------------------
// capture_filter_score_sort
// Board store, capture scoring and sorted release of a move list.
// ---------------------------------------------------------------------------
// Board load transfers write one square each. A move transfer goes through
// board read, value lookup and multiply, score sum, and one insertion step
// in the row of MAX_MOVES sorting cells. The last move of a list then
// drains the row at one result per cycle that the result side takes, and
// no input is taken until the final result has been loaded into the output
// register. A list with no capture gives a single empty result. The board
// store comes out of reset empty at once (one valid bit per square), so there
// is no clearing pass. Piece values and side to move are written over the
// APB port; the user must do so only while the block is idle (not enforced).
// ---------------------------------------------------------------------------
module capture_filter_score_sort #(
   parameter int MAX_MOVES = cfs_pkg::CFS_MAX_MOVES
) (
   input  logic                         clock,
   input  logic                         reset,
   // input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [cfs_pkg::SQ_W-1:0]     req_board_square,
   input  logic [cfs_pkg::PIECE_W-1:0]  req_square_piece,
   input  logic [cfs_pkg::KIND_W-1:0]   req_move_kind,
   input  logic [cfs_pkg::SQ_W-1:0]     req_from_square,
   input  logic [cfs_pkg::SQ_W-1:0]     req_to_square,
   input  logic [cfs_pkg::PIECE_W-1:0]  req_move_piece,
   input  logic                         req_last_move,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [cfs_pkg::IDX_W-1:0]    rsp_move_index,
   output logic signed [cfs_pkg::SCORE_W-1:0] rsp_capture_score,
   output logic [cfs_pkg::COUNT_W-1:0]  rsp_capture_count,
   output logic                         rsp_has_capture,
   output logic                         rsp_last_result,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [cfs_pkg::ADDR_W-1:0]   paddr,
   input  logic [cfs_pkg::DATA_W-1:0]   pwdata,
   output logic [cfs_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import cfs_pkg::*;

   localparam int CNT_W = $clog2(MAX_MOVES + 1);
   localparam int VPROD_W = 22;
   localparam int PPROD_W = 19;

   // Configuration
   logic [5:0][VAL_W-1:0] piece_val_ff;
   logic                  wtm_ff;
   logic [2:0]            reg_idx;
   logic                  reg_wr;

   // Board store
   logic [PIECE_W-1:0] board_mem [64];
   logic [63:0]        board_vld_ff;

   // Sequencer and move pipeline
   cfs_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    move_cnt_ff, move_cnt_in;
   logic [CNT_W-1:0]    kept_cnt_ff, kept_cnt_in;
   logic [CNT_W-1:0]    drain_left_ff, drain_left_in;
   logic                keep_ff;
   logic                last_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [PIECE_W-1:0]  promo_ff;
   logic [IDX_W-1:0]    index_ff;
   logic [PIECE_W-1:0]  from_piece_ff, to_piece_ff;
   logic                from_vld_ff, to_vld_ff;
   logic [VPROD_W-1:0]  vic_prod_ff, vic_prod_in;
   logic [VAL_W-1:0]    att_val_ff, att_val_in;
   logic [PPROD_W-1:0]  prom_prod_ff, prom_prod_in;
   logic [SCORE_W-1:0]  score_ff, score_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [SCORE_W-1:0]  rsp_score_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_has_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                load_item;
   logic                move_item;
   logic                capture_kind;
   logic                out_load;
   logic                slot_free;
   logic [PIECE_W-1:0]  att_code, vic_code;
   logic                base_ok;
   cfs_ctrl_type        row_ctrl;
   cfs_entry_type       new_entry, head;

   // Value of a piece code, zero outside the piece range
   function automatic logic [VAL_W-1:0] piece_value(
      input logic [PIECE_W-1:0]     code,
      input logic [5:0][VAL_W-1:0]  vals
   );
      logic [VAL_W-1:0] v;
      case (code) inside
         PC_W_PAWN,   PC_B_PAWN:   v = vals[CSR_PAWN];
         PC_W_KNIGHT, PC_B_KNIGHT: v = vals[CSR_KNIGHT];
         PC_W_BISHOP, PC_B_BISHOP: v = vals[CSR_BISHOP];
         PC_W_ROOK,   PC_B_ROOK:   v = vals[CSR_ROOK];
         PC_W_QUEEN,  PC_B_QUEEN:  v = vals[CSR_QUEEN];
         PC_W_KING,   PC_B_KING:   v = vals[CSR_KING];
         default:                  v = '0;
      endcase
      return v;
   endfunction

   function automatic logic in_range(input logic [PIECE_W-1:0] code);
      return (code >= PC_W_PAWN) && (code <= PC_B_KING);
   endfunction

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign reg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_val_ff[CSR_PAWN]   <= RST_PAWN;
         piece_val_ff[CSR_KNIGHT] <= RST_KNIGHT;
         piece_val_ff[CSR_BISHOP] <= RST_BISHOP;
         piece_val_ff[CSR_ROOK]   <= RST_ROOK;
         piece_val_ff[CSR_QUEEN]  <= RST_QUEEN;
         piece_val_ff[CSR_KING]   <= RST_KING;
         wtm_ff                   <= 1'b1;
      end else if (reg_wr) begin
         if (reg_idx < CSR_WTM) begin
            piece_val_ff[reg_idx] <= pwdata[VAL_W-1:0];
         end else if (reg_idx == CSR_WTM) begin
            wtm_ff <= pwdata[0];
         end
      end
   end

   // Register read-back
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         CSR_PAWN, CSR_KNIGHT, CSR_BISHOP, CSR_ROOK, CSR_QUEEN, CSR_KING: begin
            prdata = DATA_W'(piece_val_ff[reg_idx]);
         end
         CSR_WTM: begin
            prdata = DATA_W'(wtm_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // ---------------- input transfer ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_item = accept && (req_opcode == OP_LOAD);
   assign move_item = accept && (req_opcode == OP_MOVE);

   always_comb begin
      case (req_move_kind) inside
         MK_CAPTURE, MK_CAP_PROMO, MK_EN_PASS: capture_kind = 1'b1;
         default:                              capture_kind = 1'b0;
      endcase
   end

   // ---------------- board store ----------------
   always_ff @(posedge clock) begin
      if (load_item) begin
         board_mem[req_board_square] <= req_square_piece;
      end
      if (move_item) begin
         from_piece_ff <= board_mem[req_from_square];
         to_piece_ff   <= board_mem[req_to_square];
      end
   end

   // Square valid bits: an unwritten square reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         board_vld_ff <= '0;
      end else if (load_item) begin
         board_vld_ff[req_board_square] <= 1'b1;
      end
   end

   // Move details held for the scoring steps
   always_ff @(posedge clock) begin
      if (move_item) begin
         from_vld_ff <= board_vld_ff[req_from_square];
         to_vld_ff   <= board_vld_ff[req_to_square];
         kind_ff     <= req_move_kind;
         promo_ff    <= req_move_piece;
         last_ff     <= req_last_move;
         index_ff    <= IDX_W'(move_cnt_ff);
         keep_ff     <= capture_kind && (move_cnt_ff < CNT_W'(MAX_MOVES));
      end
   end

   // ---------------- scoring ----------------
   always_comb begin
      att_code = from_vld_ff ? from_piece_ff : PC_EMPTY;
      if (kind_ff == MK_EN_PASS) begin
         vic_code = wtm_ff ? PC_B_PAWN : PC_W_PAWN;
      end else begin
         vic_code = to_vld_ff ? to_piece_ff : PC_EMPTY;
      end
      base_ok = in_range(att_code) && in_range(vic_code);

      // Products
      vic_prod_in  = '0;
      att_val_in   = '0;
      prom_prod_in = '0;
      if (base_ok) begin
         vic_prod_in = VPROD_W'({7'b0, piece_value(vic_code, piece_val_ff)}
                                * VPROD_W'(VICTIM_MUL));
         att_val_in  = piece_value(att_code, piece_val_ff);
      end
      if (kind_ff == MK_CAP_PROMO) begin
         prom_prod_in = PPROD_W'({4'b0, piece_value(promo_ff, piece_val_ff)}
                                 * PPROD_W'(PROMO_MUL));
      end

      // Sum, wrapping in two's complement
      score_in = SCORE_W'({1'b0, vic_prod_ff}) - SCORE_W'(att_val_ff)
               + SCORE_W'(prom_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MULT) begin
         vic_prod_ff  <= vic_prod_in;
         att_val_ff   <= att_val_in;
         prom_prod_ff <= prom_prod_in;
      end
      if (state_ff == ST_SUM) begin
         score_ff <= score_in;
      end
   end

   // ---------------- sorting row ----------------
   assign new_entry.valid = 1'b1;
   assign new_entry.score = score_ff;
   assign new_entry.index = index_ff;

   cfs_chain #(
      .NUM_CELLS (MAX_MOVES)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (row_ctrl),
      .new_entry (new_entry),
      .head      (head)
   );

   // ---------------- sequencer ----------------
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      move_cnt_in   = move_cnt_ff;
      kept_cnt_in   = kept_cnt_ff;
      drain_left_in = drain_left_ff;
      row_ctrl      = '0;
      out_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (move_item) begin
               if (move_cnt_ff < CNT_W'(MAX_MOVES)) begin
                  move_cnt_in = move_cnt_ff + CNT_W'(1);
               end
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            row_ctrl.insert = keep_ff;
            kept_cnt_in     = kept_cnt_ff + CNT_W'(keep_ff);
            if (last_ff) begin
               drain_left_in = kept_cnt_in;
               move_cnt_in   = '0;
               state_in      = ST_DRAIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (drain_left_ff != '0) begin
                  row_ctrl.shift = 1'b1;
                  drain_left_in  = drain_left_ff - CNT_W'(1);
               end
               if (drain_left_ff <= CNT_W'(1)) begin
                  kept_cnt_in = '0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         move_cnt_ff   <= '0;
         kept_cnt_ff   <= '0;
         drain_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         move_cnt_ff   <= move_cnt_in;
         kept_cnt_ff   <= kept_cnt_in;
         drain_left_ff <= drain_left_in;
      end
   end

   // ---------------- output register ----------------
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Empty list gives one all-zero result flagged last
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (drain_left_ff == '0) begin
            rsp_index_ff <= '0;
            rsp_score_ff <= '0;
            rsp_count_ff <= '0;
            rsp_has_ff   <= 1'b0;
            rsp_last_ff  <= 1'b1;
         end else begin
            rsp_index_ff <= head.index;
            rsp_score_ff <= head.score;
            rsp_count_ff <= COUNT_W'(kept_cnt_ff);
            rsp_has_ff   <= 1'b1;
            rsp_last_ff  <= (drain_left_ff == CNT_W'(1));
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_move_index    = rsp_index_ff;
   assign rsp_capture_score = rsp_score_ff;
   assign rsp_capture_count = rsp_count_ff;
   assign rsp_has_capture   = rsp_has_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule

### hw/rtl/cfs_checker.sv
// ---------------------------------------------------------------------------
// cfs_checker
// Port-level checks on the capture sorter, bound to the top level.
// ---------------------------------------------------------------------------
module cfs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [cfs_pkg::IDX_W-1:0]    rsp_move_index,
   input logic signed [cfs_pkg::SCORE_W-1:0] rsp_capture_score,
   input logic [cfs_pkg::COUNT_W-1:0]  rsp_capture_count,
   input logic                         rsp_has_capture,
   input logic                         rsp_last_result
);
   import cfs_pkg::*;

   // A stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_move_index)
         && $stable(rsp_capture_score) && $stable(rsp_capture_count)
         && $stable(rsp_has_capture) && $stable(rsp_last_result))
      else $error("stalled result changed");

   // An empty result is the only one of its run and carries zeros
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_capture |-> rsp_last_result
         && (rsp_capture_count == '0) && (rsp_move_index == '0)
         && (rsp_capture_score == '0))
      else $error("malformed empty result");

   // Input is held off while a run is still draining
   a_drain_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> req_stall)
      else $error("input taken during drain");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind capture_filter_score_sort cfs_checker u_cfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_move_index    (rsp_move_index),
   .rsp_capture_score (rsp_capture_score),
   .rsp_capture_count (rsp_capture_count),
   .rsp_has_capture   (rsp_has_capture),
   .rsp_last_result   (rsp_last_result)
);

### dv/tb_capture_filter_score_sort.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Capture filter, scorer and sorter testbench
// Loads board squares and streams move lists through the block, predicts
// the ranked capture list that each last move releases, and checks every
// result transfer field by field. A short directed table comes first, then
// random lists under five register settings with random idling on both
// sides and register read-back over APB.
// ---------------------------------------------------------------------------
module testbench;
   import cfs_pkg::*;

   localparam int LIST_DEPTH  = CFS_MAX_MOVES;
   localparam int IDLE_LIMIT  = 1000;
   localparam int SETTLE      = 12;
   localparam int PHASE_ITEMS = 20;
   localparam int REPORT_MAX  = 10;

   // codes the package leaves unnamed
   localparam logic [KIND_W-1:0]  MK_SPARE  = 3'd7;
   localparam logic [PIECE_W-1:0] PC_BAD    = 4'd15;
   localparam logic [2:0]         CSR_SPARE = 3'd7;

   typedef struct packed {
      logic               op;
      logic [SQ_W-1:0]    board_sq;
      logic [PIECE_W-1:0] board_pc;
      logic [KIND_W-1:0]  kind;
      logic [SQ_W-1:0]    from_sq;
      logic [SQ_W-1:0]    to_sq;
      logic [PIECE_W-1:0] promo_pc;
      logic               last;
   } move_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]          index;
      logic signed [SCORE_W-1:0] score;
      logic [COUNT_W-1:0]        count;
      logic                      has_capture;
      logic                      last;
   } ranked_capture_type;

   typedef struct packed {
      move_item_type      item;
      logic               typed;
      ranked_capture_type want;
   } table_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_opcode = 1'b0;
   logic [SQ_W-1:0]     req_board_square = '0;
   logic [PIECE_W-1:0]  req_square_piece = '0;
   logic [KIND_W-1:0]   req_move_kind = '0;
   logic [SQ_W-1:0]     req_from_square = '0;
   logic [SQ_W-1:0]     req_to_square = '0;
   logic [PIECE_W-1:0]  req_move_piece = '0;
   logic                req_last_move = 1'b0;
   logic                rsp_stall = 1'b0;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   wire                 req_stall;
   wire                 rsp_valid;
   wire [IDX_W-1:0]     rsp_move_index;
   wire signed [SCORE_W-1:0] rsp_capture_score;
   wire [COUNT_W-1:0]   rsp_capture_count;
   wire                 rsp_has_capture;
   wire                 rsp_last_result;
   wire [DATA_W-1:0]    prdata;
   wire                 pready;

   capture_filter_score_sort dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_board_square  (req_board_square),
      .req_square_piece  (req_square_piece),
      .req_move_kind     (req_move_kind),
      .req_from_square   (req_from_square),
      .req_to_square     (req_to_square),
      .req_move_piece    (req_move_piece),
      .req_last_move     (req_last_move),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_move_index    (rsp_move_index),
      .rsp_capture_score (rsp_capture_score),
      .rsp_capture_count (rsp_capture_count),
      .rsp_has_capture   (rsp_has_capture),
      .rsp_last_result   (rsp_last_result),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Predictor state: board, piece values, side to move and the ranked row
   logic [PIECE_W-1:0] board_copy [64];
   logic [VAL_W-1:0]   piece_worth_tab [6];
   logic               side_white;
   int                 rank_index [LIST_DEPTH];
   int                 rank_score [LIST_DEPTH];
   int                 kept_captures = 0;
   int                 moves_in_list = 0;
   ranked_capture_type pending_ranked [$];

   int  fail_count = 0;
   int  items_sent = 0;
   int  moves_sent = 0;
   int  lists_sent = 0;
   int  results_checked = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  no_idle = 1'b0;

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%s", msg);
   endtask

   function automatic int piece_worth(input logic [PIECE_W-1:0] code);
      if (code < PC_W_PAWN || code > PC_B_KING)
         return 0;
      return int'(piece_worth_tab[(int'(code) - 1) % 6]);
   endfunction

   function automatic ranked_capture_type ranked_result(input int index, input int score,
                                                        input int count, input bit has,
                                                        input bit last);
      ranked_capture_type r;
      r.index       = index[IDX_W-1:0];
      r.score       = score[SCORE_W-1:0];
      r.count       = count[COUNT_W-1:0];
      r.has_capture = has;
      r.last        = last;
      return r;
   endfunction

   // Score one accepted item, place captures in the ranked row, release on last
   task automatic rank_move(input move_item_type it, output int produced);
      logic [PIECE_W-1:0] att;
      logic [PIECE_W-1:0] vic;
      int                 sc;
      int                 pos;
      int                 k;
      produced = 0;
      if (it.op == OP_LOAD) begin
         board_copy[it.board_sq] = it.board_pc;
         return;
      end
      if (moves_in_list < LIST_DEPTH) begin
         if (it.kind == MK_CAPTURE || it.kind == MK_CAP_PROMO || it.kind == MK_EN_PASS) begin
            att = board_copy[it.from_sq];
            if (it.kind == MK_EN_PASS)
               vic = side_white ? PC_B_PAWN : PC_W_PAWN;
            else
               vic = board_copy[it.to_sq];
            sc = 0;
            if (att >= PC_W_PAWN && att <= PC_B_KING && vic >= PC_W_PAWN && vic <= PC_B_KING)
               sc = piece_worth(vic) * VICTIM_MUL - piece_worth(att);
            if (it.kind == MK_CAP_PROMO)
               sc += piece_worth(it.promo_pc) * PROMO_MUL;
            // equal scores stay behind earlier arrivals
            pos = 0;
            while (pos < kept_captures && rank_score[pos] >= sc)
               pos++;
            for (k = kept_captures; k > pos; k--) begin
               rank_score[k] = rank_score[k-1];
               rank_index[k] = rank_index[k-1];
            end
            rank_score[pos] = sc;
            rank_index[pos] = moves_in_list;
            kept_captures++;
         end
         moves_in_list++;
      end
      if (!it.last)
         return;
      if (kept_captures == 0) begin
         pending_ranked.push_back(ranked_result(0, 0, 0, 1'b0, 1'b1));
         produced = 1;
      end else begin
         for (k = 0; k < kept_captures; k++)
            pending_ranked.push_back(ranked_result(rank_index[k], rank_score[k], kept_captures,
                                                   1'b1, k == kept_captures - 1));
         produced = kept_captures;
      end
      kept_captures = 0;
      moves_in_list = 0;
   endtask

   // One input transfer: random gap, drive at the falling edge, wait for acceptance
   task automatic transfer_item(input move_item_type it, output int produced);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode       <= it.op;
      req_board_square <= it.board_sq;
      req_square_piece <= it.board_pc;
      req_move_kind    <= it.kind;
      req_from_square  <= it.from_sq;
      req_to_square    <= it.to_sq;
      req_move_piece   <= it.promo_pc;
      req_last_move    <= it.last;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      rank_move(it, produced);
      items_sent++;
      if (it.op == OP_MOVE)
         moves_sent++;
      if (it.op == OP_MOVE && it.last)
         lists_sent++;
   endtask

   // Drop valid and wait for the last ranked capture plus pipeline slack
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_ranked.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx <= CSR_KING)
         piece_worth_tab[idx] = data[VAL_W-1:0];
      else if (idx == CSR_WTM)
         side_white = data[0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [2:0] idx);
      logic [DATA_W-1:0] want;
      want = '0;
      if (idx <= CSR_KING)
         want[VAL_W-1:0] = piece_worth_tab[idx];
      else
         want[0] = side_white;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         note_failure($sformatf("register %0d read: expected %0h, got %0h", idx, want, prdata));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Register settings: all high, all zero, mixed extremes, then random
   task automatic load_setting(input int setting);
      logic [VAL_W-1:0] v;
      logic             w;
      int               i;
      w = 1'($urandom_range(0, 1));
      if (setting == 1)
         w = 1'b0;
      else if (setting == 2)
         w = 1'b1;
      for (i = CSR_PAWN; i <= CSR_KING; i++) begin
         v = VAL_W'($urandom_range(0, 32767));
         case (setting)
            1: v = 15'h7FFF;
            2: v = 15'h0000;
            3: begin
               if (i == CSR_PAWN)
                  v = 15'h0000;
               else if (i == CSR_KNIGHT || i == CSR_KING)
                  v = 15'h7FFF;
            end
            default: ;
         endcase
         csr_write(3'(i), {17'($urandom_range(0, 131071)), v});
      end
      csr_write(CSR_WTM, {31'($urandom_range(0, 32'h7FFF_FFFF)), w});
      // unmapped index must leave every register alone
      if (setting == 1)
         csr_write(CSR_SPARE, $urandom());
      for (i = CSR_PAWN; i <= CSR_WTM; i++)
         csr_read_check(3'(i));
   endtask

   function automatic logic [PIECE_W-1:0] random_piece();
      int r;
      r = $urandom_range(0, 15);
      if (r < 12)
         return 4'(r + 1);
      if (r == 12)
         return PC_EMPTY;
      return 4'($urandom_range(13, 15));
   endfunction

   // Mostly occupied squares so that captures score against real pieces
   function automatic logic [SQ_W-1:0] pick_square();
      logic [SQ_W-1:0] sq;
      int              t;
      sq = SQ_W'($urandom_range(0, 63));
      if ($urandom_range(0, 3) != 0)
         for (t = 0; t < 8 && board_copy[sq] == PC_EMPTY; t++)
            sq = SQ_W'($urandom_range(0, 63));
      return sq;
   endfunction

   function automatic move_item_type random_item(input logic op);
      logic [31:0]   junk;
      move_item_type it;
      junk = $urandom();
      it   = junk[$bits(move_item_type)-1:0];
      it.op = op;
      if (op == OP_LOAD) begin
         it.board_pc = random_piece();
      end else begin
         it.from_sq  = pick_square();
         it.to_sq    = pick_square();
         it.promo_pc = random_piece();
         it.last     = 1'b0;
      end
      return it;
   endfunction

   // A move list with a few loads in front and some mixed in
   task automatic send_move_list(input int n_moves, input bit all_captures);
      move_item_type it;
      int            m;
      int            r;
      int            produced;
      repeat ($urandom_range(0, 3)) transfer_item(random_item(OP_LOAD), produced);
      for (m = 0; m < n_moves; m++) begin
         if (!all_captures && $urandom_range(0, 7) == 0)
            transfer_item(random_item(OP_LOAD), produced);
         it = random_item(OP_MOVE);
         r  = $urandom_range(0, 9);
         if (all_captures || r < 6)
            it.kind = KIND_W'($urandom_range(MK_CAPTURE, MK_EN_PASS));
         else if (r == 6)
            it.kind = MK_QUIET;
         else if (r == 7)
            it.kind = MK_PROMO;
         else if (r == 8)
            it.kind = KIND_W'($urandom_range(MK_PROMO + 1, MK_SPARE));
         it.last = (m == n_moves - 1);
         transfer_item(it, produced);
      end
   endtask

   function automatic table_row_type load_row(input logic [SQ_W-1:0] sq,
                                              input logic [PIECE_W-1:0] pc);
      table_row_type row;
      row = '0;
      row.item.op       = OP_LOAD;
      row.item.board_sq = sq;
      row.item.board_pc = pc;
      return row;
   endfunction

   function automatic table_row_type move_row(input logic [KIND_W-1:0] kind,
                                              input logic [SQ_W-1:0] from_sq,
                                              input logic [SQ_W-1:0] to_sq,
                                              input logic [PIECE_W-1:0] pc,
                                              input logic last);
      table_row_type row;
      row = '0;
      row.item.op       = OP_MOVE;
      row.item.kind     = kind;
      row.item.from_sq  = from_sq;
      row.item.to_sq    = to_sq;
      row.item.promo_pc = pc;
      row.item.last     = last;
      return row;
   endfunction

   // Result side: per-result stall drawn on acceptance, applied at falling edges
   always @(negedge clock) begin
      rsp_stall <= (stall_left > 0);
   end

   // Check each result transfer against the oldest ranked capture
   always @(posedge clock) begin : result_check
      ranked_capture_type want;
      ranked_capture_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.index       = rsp_move_index;
         got.score       = rsp_capture_score;
         got.count       = rsp_capture_count;
         got.has_capture = rsp_has_capture;
         got.last        = rsp_last_result;
         if (pending_ranked.size() == 0) begin
            note_failure($sformatf("unexpected result: index %0d score %0d count %0d has %0b last %0b",
                                   got.index, got.score, got.count, got.has_capture, got.last));
         end else begin
            want = pending_ranked.pop_front();
            if (got.index !== want.index || got.score !== want.score ||
                got.count !== want.count || got.has_capture !== want.has_capture ||
                got.last !== want.last)
               note_failure($sformatf({"result mismatch: expected index %0d score %0d count %0d",
                                       " has %0b last %0b, got index %0d score %0d count %0d",
                                       " has %0b last %0b"},
                                      want.index, want.score, want.count, want.has_capture,
                                      want.last, got.index, got.score, got.count,
                                      got.has_capture, got.last));
         end
         results_checked++;
         stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("capture_filter_score_sort test failed");
            $finish;
         end
      end
   end

   initial begin
      table_row_type directed [$];
      table_row_type row;
      int            produced;
      int            setting;
      int            phase_start;
      int            r;
      bit            overflow_done;

      // predictor starts from the reset state
      foreach (board_copy[i])
         board_copy[i] = PC_EMPTY;
      piece_worth_tab[CSR_PAWN]   = RST_PAWN;
      piece_worth_tab[CSR_KNIGHT] = RST_KNIGHT;
      piece_worth_tab[CSR_BISHOP] = RST_BISHOP;
      piece_worth_tab[CSR_ROOK]   = RST_ROOK;
      piece_worth_tab[CSR_QUEEN]  = RST_QUEEN;
      piece_worth_tab[CSR_KING]   = RST_KING;
      side_white    = 1'b1;
      overflow_done = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table under reset values
      row = move_row(MK_QUIET, 6'd0, 6'd0, PC_EMPTY, 1'b1);     // empty list after reset
      row.typed = 1'b1;
      row.want  = ranked_result(0, 0, 0, 1'b0, 1'b1);
      directed.push_back(row);
      directed.push_back(load_row(6'd0, PC_W_PAWN));
      directed.push_back(load_row(6'd63, PC_B_QUEEN));
      row = move_row(MK_CAPTURE, 6'd0, 6'd63, PC_EMPTY, 1'b1);  // pawn takes queen
      row.typed = 1'b1;
      row.want  = ranked_result(0, 89900, 1, 1'b1, 1'b1);
      directed.push_back(row);
      directed.push_back(load_row(6'd1, PC_W_KING));
      directed.push_back(load_row(6'd2, PC_B_KING));
      directed.push_back(load_row(6'd3, PC_BAD));
      directed.push_back(move_row(MK_CAPTURE, 6'd1, 6'd2, PC_EMPTY, 1'b0));
      directed.push_back(move_row(MK_CAP_PROMO, 6'd0, 6'd63, PC_B_QUEEN, 1'b0));
      directed.push_back(move_row(MK_EN_PASS, 6'd0, 6'd5, PC_EMPTY, 1'b0));
      directed.push_back(move_row(MK_CAPTURE, 6'd3, 6'd63, PC_EMPTY, 1'b0));   // bad attacker
      directed.push_back(move_row(MK_CAPTURE, 6'd0, 6'd4, PC_EMPTY, 1'b0));    // empty victim
      directed.push_back(move_row(MK_CAP_PROMO, 6'd4, 6'd4, PC_BAD, 1'b0));    // bad promotion
      directed.push_back(move_row(MK_PROMO, 6'd0, 6'd63, PC_W_QUEEN, 1'b0));
      directed.push_back(move_row(MK_SPARE, 6'd0, 6'd63, PC_B_KING, 1'b0));
      directed.push_back(move_row(MK_QUIET, 6'd63, 6'd0, PC_BAD, 1'b1));
      directed.push_back(load_row(6'd63, PC_EMPTY));
      row = move_row(MK_CAPTURE, 6'd0, 6'd63, PC_EMPTY, 1'b1);  // cleared square
      row.typed = 1'b1;
      row.want  = ranked_result(0, 0, 1, 1'b1, 1'b1);
      directed.push_back(row);

      foreach (directed[i]) begin
         transfer_item(directed[i].item, produced);
         if (directed[i].typed && produced == 1)
            pending_ranked[pending_ranked.size() - 1] = directed[i].want;
      end
      wait_for_results();

      // Random lists, one block per register setting
      for (setting = 1; setting <= 5; setting++) begin
         load_setting(setting);
         repeat (12) transfer_item(random_item(OP_LOAD), produced);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (setting == 3 && !overflow_done) begin
               // overlong list of captures fills the whole row
               send_move_list(LIST_DEPTH + 6, 1'b1);
               overflow_done = 1'b1;
            end else begin
               r = $urandom_range(0, 9);
               send_move_list(r == 0 ? $urandom_range(13, 30) : $urandom_range(1, 12), 1'b0);
            end
         end
         no_idle = 1'b0;
         wait_for_results();
      end

      $display("Covered %0d input transfers: %0d moves in %0d lists, %0d results checked.",
               items_sent, moves_sent, lists_sent, results_checked);
      $display("Reset values plus five register settings, overlong list included; %0d failures.",
               fail_count);
      if (fail_count == 0) begin
         $display("capture_filter_score_sort test passed");
      end else begin
         $display("capture_filter_score_sort test failed");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/cfs_pkg.sv
hw/rtl/cfs_cell.sv
hw/rtl/cfs_chain.sv
hw/rtl/capture_filter_score_sort.sv
hw/rtl/cfs_checker.sv
dv/tb_capture_filter_score_sort.sv
